@@ rtl/core/ccps_pkg.sv @@
// ----------------------------------------------------------------------------
// ccps_pkg
// Shared types and constants for the closest-point-on-segment pipeline.
// ----------------------------------------------------------------------------
package ccps_pkg;

  localparam int FRAC_BITS = 12;
  localparam int QBITS     = FRAC_BITS + 1;
  localparam logic [QBITS-1:0] ONE_FX = 13'h1000;
  localparam logic [5:0] SHIFT_MAX = 6'd12;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } vec3_t;

  // A and the edge E travel with each word to the back end
  typedef struct packed {
    vec3_t a;
    vec3_t e;
  } geom_t;

  // Divider stage contents
  typedef struct packed {
    logic             vld;
    logic             ok;
    logic             ovf;
    logic [31:0]      rem;
    logic [31:0]      dm;
    logic [QBITS-1:0] q;
    geom_t            g;
  } div_st_t;

endpackage

@@ rtl/core/ccps_front.sv @@
// ----------------------------------------------------------------------------
// ccps_front
// Edge and offset, dot products, sign normalisation. Four register stages.
// ----------------------------------------------------------------------------
module ccps_front
  import ccps_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  vec3_t              pa,
  input  vec3_t              pb,
  input  vec3_t              pp,
  output logic               out_vld,
  output geom_t              out_g,
  output logic signed [31:0] out_num,
  output logic signed [31:0] out_den
);

  // stage 1: E = B - A, D = P - A
  logic  v1_r;
  geom_t g1_r;
  vec3_t d1_r;
  // stage 2: products
  logic  v2_r;
  geom_t g2_r;
  logic signed [31:0] ee_r [0:2];
  logic signed [31:0] de_r [0:2];
  // stage 3: sums
  logic  v3_r;
  geom_t g3_r;
  logic signed [31:0] num3_r, den3_r;
  // stage 4: normalised
  logic  v4_r;
  geom_t g4_r;
  logic signed [31:0] num4_r, den4_r;

  geom_t g1_nxt;
  vec3_t d1_nxt;
  logic [5:0] cnt;
  logic [5:0] s_nxt;
  logic [31:0] sum_ee, sum_de;

  always_comb begin
    g1_nxt.a   = pa;
    g1_nxt.e.x = pb.x - pa.x;
    g1_nxt.e.y = pb.y - pa.y;
    g1_nxt.e.z = pb.z - pa.z;
    d1_nxt.x   = pp.x - pa.x;
    d1_nxt.y   = pp.y - pa.y;
    d1_nxt.z   = pp.z - pa.z;
  end

  assign sum_ee = ee_r[0] + ee_r[1] + ee_r[2];
  assign sum_de = de_r[0] + de_r[1] + de_r[2];

  // leading sign bits of D.E, then s = clamp(count - 2, 0, 12)
  always_comb begin
    cnt = 6'd32;
    for (int i = 0; i < 31; i++) begin
      if (num3_r[i] != num3_r[31]) cnt = 6'(31 - i);
    end
    if (cnt < 6'd2) s_nxt = 6'd0;
    else if (cnt - 6'd2 > SHIFT_MAX) s_nxt = SHIFT_MAX;
    else s_nxt = cnt - 6'd2;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      g1_r    <= g1_nxt;
      d1_r    <= d1_nxt;
      g2_r    <= g1_r;
      ee_r[0] <= g1_r.e.x * g1_r.e.x;
      ee_r[1] <= g1_r.e.y * g1_r.e.y;
      ee_r[2] <= g1_r.e.z * g1_r.e.z;
      de_r[0] <= d1_r.x * g1_r.e.x;
      de_r[1] <= d1_r.y * g1_r.e.y;
      de_r[2] <= d1_r.z * g1_r.e.z;
      g3_r    <= g2_r;
      num3_r  <= sum_de;
      den3_r  <= sum_ee;
      g4_r    <= g3_r;
      num4_r  <= num3_r <<< s_nxt;
      den4_r  <= den3_r >>> (SHIFT_MAX - s_nxt);
    end
  end

  assign out_vld = v4_r;
  assign out_g   = g4_r;
  assign out_num = num4_r;
  assign out_den = den4_r;

endmodule

@@ rtl/core/ccps_div.sv @@
// ----------------------------------------------------------------------------
// ccps_div
// Pipelined restoring divider, one quotient bit per stage, result 0..4096.
// ----------------------------------------------------------------------------
module ccps_div
  import ccps_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  geom_t              in_g,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic               out_vld,
  output geom_t              out_g,
  output logic [QBITS-1:0]   t
);

  div_st_t st_r   [0:QBITS];
  div_st_t st_nxt [0:QBITS];

  logic [31:0] n_abs, d_abs;

  // set-up: magnitudes, sign agreement, quotient overflow
  always_comb begin
    n_abs = num[31] ? 32'(-num) : 32'(num);
    d_abs = den[31] ? 32'(-den) : 32'(den);
    st_nxt[0].vld = in_vld;
    st_nxt[0].ok  = (den != 32'sd0) && (num[31] == den[31]);
    st_nxt[0].ovf = {13'd0, n_abs} >= {d_abs, 13'd0};
    st_nxt[0].rem = n_abs;
    st_nxt[0].dm  = d_abs;
    st_nxt[0].q   = '0;
    st_nxt[0].g   = in_g;
  end

  for (genvar j = 0; j < QBITS; j++) begin : g_stage
    localparam int K = QBITS - 1 - j;
    logic [44:0] trial;
    always_comb begin
      trial = {13'd0, st_r[j].dm} << K;
      st_nxt[j+1] = st_r[j];
      if ({13'd0, st_r[j].rem} >= trial) begin
        st_nxt[j+1].rem  = st_r[j].rem - trial[31:0];
        st_nxt[j+1].q[K] = 1'b1;
      end
    end
  end

  for (genvar j = 0; j <= QBITS; j++) begin : g_reg
    always_ff @(posedge clk) begin
      if (!rst_n) st_r[j].vld <= 1'b0;
      else if (en) st_r[j] <= st_nxt[j];
    end
  end

  // clamp to 0..4096
  always_comb begin
    if (!st_r[QBITS].ok) t = '0;
    else if (st_r[QBITS].ovf || st_r[QBITS].q > ONE_FX) t = ONE_FX;
    else t = st_r[QBITS].q;
  end

  assign out_vld = st_r[QBITS].vld;
  assign out_g   = st_r[QBITS].g;

endmodule

@@ rtl/core/ccps_back.sv @@
// ----------------------------------------------------------------------------
// ccps_back
// Scales E by t and adds A; the last stage is the output register.
// ----------------------------------------------------------------------------
module ccps_back
  import ccps_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  geom_t            in_g,
  input  logic [QBITS-1:0] t,
  output logic             out_vld,
  output vec3_t            out_p
);

  logic  vm_r, vo_r;
  vec3_t am_r, po_r;
  logic signed [29:0] pr_r [0:2];
  logic signed [QBITS:0] ts;

  assign ts = $signed({1'b0, t});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      vm_r <= in_vld;
      vo_r <= vm_r;
    end
  end

  // t*E, then A + floor(t*E / 4096)
  always_ff @(posedge clk) begin
    if (en) begin
      am_r     <= in_g.a;
      pr_r[0]  <= 30'(ts) * 30'(in_g.e.x);
      pr_r[1]  <= 30'(ts) * 30'(in_g.e.y);
      pr_r[2]  <= 30'(ts) * 30'(in_g.e.z);
      po_r.x   <= am_r.x + pr_r[0][27:12];
      po_r.y   <= am_r.y + pr_r[1][27:12];
      po_r.z   <= am_r.z + pr_r[2][27:12];
    end
  end

  assign out_vld = vo_r;
  assign out_p   = po_r;

endmodule

@@ rtl/core/closest_point_on_segment_fixed.sv @@
// ----------------------------------------------------------------------------
// closest_point_on_segment_fixed
// Nearest point on segment AB to query P, 16-bit fixed point, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | ports                          | width
//  in      | in_valid/in_ready, in_* coords | 9 x 16 signed
//  out     | out_valid/out_ready, out_*     | 3 x 16 signed
//
// One word enters per cycle while out is not stalled; the pipeline has 4 front,
// 14 divider and 2 back stages, the last of which is the output register. The divider's 14
// stages set the depth.
// Reset clears only the valid bits. A stall on out freezes the whole
// pipeline; in_ready is low exactly while a held result is not taken.
module closest_point_on_segment_fixed
  import ccps_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_seg_a_x,
  input  logic signed [15:0] in_seg_a_y,
  input  logic signed [15:0] in_seg_a_z,
  input  logic signed [15:0] in_seg_b_x,
  input  logic signed [15:0] in_seg_b_y,
  input  logic signed [15:0] in_seg_b_z,
  input  logic signed [15:0] in_query_x,
  input  logic signed [15:0] in_query_y,
  input  logic signed [15:0] in_query_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_nearest_x,
  output logic signed [15:0] out_nearest_y,
  output logic signed [15:0] out_nearest_z
);

  logic en;
  vec3_t pa, pb, pp, res;
  logic fv, dv;
  geom_t fg, dg;
  logic signed [31:0] fnum, fden;
  logic [QBITS-1:0] t;

  // pipeline advances unless the output word is held
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  assign pa = '{x: in_seg_a_x, y: in_seg_a_y, z: in_seg_a_z};
  assign pb = '{x: in_seg_b_x, y: in_seg_b_y, z: in_seg_b_z};
  assign pp = '{x: in_query_x, y: in_query_y, z: in_query_z};

  ccps_front u_front (
    .clk, .rst_n, .en,
    .in_vld  (in_valid),
    .pa, .pb, .pp,
    .out_vld (fv),
    .out_g   (fg),
    .out_num (fnum),
    .out_den (fden)
  );

  ccps_div u_div (
    .clk, .rst_n, .en,
    .in_vld  (fv),
    .in_g    (fg),
    .num     (fnum),
    .den     (fden),
    .out_vld (dv),
    .out_g   (dg),
    .t
  );

  ccps_back u_back (
    .clk, .rst_n, .en,
    .in_vld  (dv),
    .in_g    (dg),
    .t,
    .out_vld (out_valid),
    .out_p   (res)
  );

  assign out_nearest_x = res.x;
  assign out_nearest_y = res.y;
  assign out_nearest_z = res.z;

endmodule
